@@ design/websocket_frame_deframer_assert.svh @@
// assertion macros shared by the deframer checker
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define WSDF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, disabled while reset is asserted
`define WSDF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

@@ design/wsdf_pkg.sv @@
// types and constants of the websocket frame deframer
package wsdf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned INDEX_W  = 17;
    localparam int unsigned STATUS_W = 3;

    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    localparam logic [BYTE_W-1:0] FIN_MASK    = 8'h80;
    localparam logic [3:0]        OPC_BINARY  = 4'h2;
    localparam logic [3:0]        OPC_CLOSE   = 4'h8;
    localparam logic [6:0]        LEN_EXT16   = 7'd126;
    localparam logic [6:0]        LEN_EXT64   = 7'd127;

    typedef enum logic [STATUS_W-1:0] {
        ST_PENDING  = 3'd0,
        ST_ACCEPT   = 3'd1,
        ST_NOTFIN   = 3'd2,
        ST_NOTBIN   = 3'd3,
        ST_CLOSE    = 3'd4,
        ST_LEN64    = 3'd5,
        ST_MISMATCH = 3'd6
    } status_t;

    typedef enum logic [9:0] {
        PH_HDR0 = 10'b00_0000_0001,
        PH_HDR1 = 10'b00_0000_0010,
        PH_EXT0 = 10'b00_0000_0100,
        PH_EXT1 = 10'b00_0000_1000,
        PH_KEY0 = 10'b00_0001_0000,
        PH_KEY1 = 10'b00_0010_0000,
        PH_KEY2 = 10'b00_0100_0000,
        PH_KEY3 = 10'b00_1000_0000,
        PH_DATA = 10'b01_0000_0000,
        PH_DROP = 10'b10_0000_0000
    } phase_t;

endpackage

@@ design/websocket_frame_deframer.sv @@
// websocket frame deframer: header parse, mask key capture and payload unmasking
// output: each accepted input word gives a registered result word on the m_ side in the next cycle
// throughput: one word per cycle; the single output register is refilled in the
// same cycle it is drained, so s_tready only drops while a result waits unread
// reset: aresetn low (synchronous) returns the parser to await a first header byte
// with length, key, payload count and verdict cleared, and empties the output register
module websocket_frame_deframer
    import wsdf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_of_read
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
    output logic        m_tuser,   // byte_valid
    output logic        m_tlast    // frame_done
);

    // parser state
    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    length_reg, length_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    status_t             verdict_reg, verdict_next;

    // result register
    logic                m_valid_reg;
    logic [BYTE_W-1:0]   ob_reg;
    logic                bv_reg;
    logic                done_reg;
    status_t             status_reg;

    // combinational result of the word being accepted
    logic [BYTE_W-1:0]   ob_next;
    logic                bv_next;
    status_t             status_next;
    logic [BYTE_W-1:0]   key_byte;
    logic                accept;

    // the output register is free when empty or being drained this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // key byte for the current payload position, first key byte first
    always_comb begin
        unique case (index_reg[1:0])
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            2'd3: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        key_next     = key_reg;
        index_next   = index_reg;
        verdict_next = verdict_reg;
        ob_next      = '0;
        bv_next      = 1'b0;
        status_next  = ST_PENDING;

        unique case (phase_reg)
            PH_HDR0: begin
                // fin clear, then close, then anything not binary
                if ((s_tdata & FIN_MASK) == '0) begin
                    verdict_next = ST_NOTFIN;
                    phase_next   = PH_DROP;
                end else if (s_tdata[3:0] == OPC_CLOSE) begin
                    verdict_next = ST_CLOSE;
                    phase_next   = PH_DROP;
                end else if (s_tdata[3:0] != OPC_BINARY) begin
                    verdict_next = ST_NOTBIN;
                    phase_next   = PH_DROP;
                end else begin
                    phase_next = PH_HDR1;
                end
            end
            PH_HDR1: begin
                // mask bit is ignored, a key is always taken
                if (s_tdata[6:0] == LEN_EXT64) begin
                    verdict_next = ST_LEN64;
                    phase_next   = PH_DROP;
                end else if (s_tdata[6:0] == LEN_EXT16) begin
                    phase_next = PH_EXT0;
                end else begin
                    length_next = {{(LEN_W-7){1'b0}}, s_tdata[6:0]};
                    phase_next  = PH_KEY0;
                end
            end
            PH_EXT0: begin
                length_next = {s_tdata, {BYTE_W{1'b0}}};
                phase_next  = PH_EXT1;
            end
            PH_EXT1: begin
                length_next = {length_reg[LEN_W-1:BYTE_W], s_tdata};
                phase_next  = PH_KEY0;
            end
            PH_KEY0: begin
                key_next   = {key_reg[KEY_W-BYTE_W-1:0], s_tdata};
                phase_next = PH_KEY1;
            end
            PH_KEY1: begin
                key_next   = {key_reg[KEY_W-BYTE_W-1:0], s_tdata};
                phase_next = PH_KEY2;
            end
            PH_KEY2: begin
                key_next   = {key_reg[KEY_W-BYTE_W-1:0], s_tdata};
                phase_next = PH_KEY3;
            end
            PH_KEY3: begin
                key_next   = {key_reg[KEY_W-BYTE_W-1:0], s_tdata};
                phase_next = PH_DATA;
            end
            PH_DATA: begin
                ob_next = s_tdata ^ key_byte;
                bv_next = 1'b1;
                // payload count saturates at its top value
                if (index_reg != INDEX_MAX) begin
                    index_next = index_reg + 1'b1;
                end
            end
            PH_DROP: begin
                // rejected frame, swallow until the chunk ends
            end
            default: begin
                phase_next = PH_HDR0;
            end
        endcase

        // chunk end: report the verdict and return to the reset state
        if (s_tlast) begin
            priority if (verdict_next != ST_PENDING) begin
                status_next = verdict_next;
            end else if (phase_next == PH_DATA &&
                         index_next == {{(INDEX_W-LEN_W){1'b0}}, length_next}) begin
                status_next = ST_ACCEPT;
            end else begin
                // also covers a header cut short before the last key byte
                status_next = ST_MISMATCH;
            end
            phase_next   = PH_HDR0;
            length_next  = '0;
            key_next     = '0;
            index_next   = '0;
            verdict_next = ST_PENDING;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            length_reg  <= '0;
            key_reg     <= '0;
            index_reg   <= '0;
            verdict_reg <= ST_PENDING;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                length_reg  <= length_next;
                key_reg     <= key_next;
                index_reg   <= index_next;
                verdict_reg <= verdict_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with every accepted word
    always_ff @(posedge aclk) begin
        if (accept) begin
            ob_reg     <= ob_next;
            bv_reg     <= bv_next;
            done_reg   <= s_tlast;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16-BYTE_W-STATUS_W){1'b0}}, status_reg, ob_reg};
    assign m_tuser  = bv_reg;
    assign m_tlast  = done_reg;

endmodule

@@ design/wsdf_checker.sv @@
// port-level checker for the websocket frame deframer, with its bind
`include "websocket_frame_deframer_assert.svh"

module wsdf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled result word holds
    `WSDF_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // input is only back-pressured by a waiting, unread result
    `WSDF_ASSERT_NOW(a_ready, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

    // a verdict only appears on the word that closes a chunk
    `WSDF_ASSERT_NOW(a_status, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[10:8] == 3'd0)

    // non-payload words carry a zero byte
    `WSDF_ASSERT_NOW(a_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[7:0] == 8'd0)

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (.*);

@@ tb/tb_websocket_frame_deframer.sv @@
// self-checking stream testbench for the websocket frame deframer
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
    import wsdf_pkg::*;

    // one raw byte of a read chunk, with pacing hints for the sender
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;  // hold this word back until every result is in
        logic       quiet;  // no idling on either side around this word
    } chunk_word_t;

    // one expected result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_done;
        status_t    status;
    } deframed_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // [7:0] in_byte
    logic        s_tlast  = 1'b0;   // last_of_read
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] out_byte, [10:8] status, [15:11] zero
    logic        m_tuser;           // byte_valid
    logic        m_tlast;           // frame_done

    websocket_frame_deframer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // words still to be sent, and results still owed by the block
    chunk_word_t    chunk_bytes_q[$];
    deframed_word_t deframed_q[$];

    // pacing state
    logic word_taken   = 1'b0;  // input handshake seen at the last rising edge
    logic result_taken = 1'b0;  // output handshake seen at the last rising edge
    logic quiet        = 1'b0;  // the word on the bus asks for no idling
    int   send_wait    = 0;
    int   recv_wait    = 0;

    // stimulus build flags, consumed by queue_word
    logic quiet_mode    = 1'b0;
    logic drain_pending = 1'b0;

    int bad_words = 0;

    // ------------------------------------------------------------------
    // predictor state: header parser, key, payload count and verdict
    // ------------------------------------------------------------------
    phase_t      hdr_phase     = PH_HDR0;
    logic [15:0] frame_len     = '0;
    logic [31:0] unmask_key    = '0;
    logic [16:0] payload_count = '0;
    status_t     verdict       = ST_PENDING;

    function automatic void clear_deframer();
        hdr_phase     = PH_HDR0;
        frame_len     = '0;
        unmask_key    = '0;
        payload_count = '0;
        verdict       = ST_PENDING;
    endfunction

    // advance the parser by one byte and return the word the block owes for it
    function automatic deframed_word_t deframe_byte(logic [7:0] b, logic last);
        deframed_word_t r;
        logic [1:0]     key_sel;
        r.out_byte   = '0;
        r.byte_valid = 1'b0;
        r.frame_done = last;
        r.status     = ST_PENDING;
        case (hdr_phase)
            PH_HDR0: begin
                // fin first, then close, then any other non-binary opcode
                if ((b & FIN_MASK) == '0) begin
                    verdict   = ST_NOTFIN;
                    hdr_phase = PH_DROP;
                end else if (b[3:0] == OPC_CLOSE) begin
                    verdict   = ST_CLOSE;
                    hdr_phase = PH_DROP;
                end else if (b[3:0] != OPC_BINARY) begin
                    verdict   = ST_NOTBIN;
                    hdr_phase = PH_DROP;
                end else begin
                    hdr_phase = PH_HDR1;
                end
            end
            PH_HDR1: begin
                // mask bit is ignored, a key is always taken
                if (b[6:0] == LEN_EXT64) begin
                    verdict   = ST_LEN64;
                    hdr_phase = PH_DROP;
                end else if (b[6:0] == LEN_EXT16) begin
                    hdr_phase = PH_EXT0;
                end else begin
                    frame_len = {9'd0, b[6:0]};
                    hdr_phase = PH_KEY0;
                end
            end
            PH_EXT0: begin
                frame_len = {b, 8'h00};
                hdr_phase = PH_EXT1;
            end
            PH_EXT1: begin
                frame_len = {frame_len[15:8], b};
                hdr_phase = PH_KEY0;
            end
            PH_KEY0: begin
                unmask_key = {unmask_key[23:0], b};
                hdr_phase  = PH_KEY1;
            end
            PH_KEY1: begin
                unmask_key = {unmask_key[23:0], b};
                hdr_phase  = PH_KEY2;
            end
            PH_KEY2: begin
                unmask_key = {unmask_key[23:0], b};
                hdr_phase  = PH_KEY3;
            end
            PH_KEY3: begin
                unmask_key = {unmask_key[23:0], b};
                hdr_phase  = PH_DATA;
            end
            PH_DATA: begin
                // first key byte sits in the top bits; the count saturates
                key_sel      = 2'd3 - payload_count[1:0];
                r.out_byte   = b ^ unmask_key[key_sel*8 +: 8];
                r.byte_valid = 1'b1;
                if (payload_count != INDEX_MAX)
                    payload_count = payload_count + 1'b1;
            end
            default: begin
                // rejected frame: swallow the rest of the chunk
            end
        endcase
        if (last) begin
            if (verdict != ST_PENDING)
                r.status = verdict;
            else if (hdr_phase == PH_DATA && payload_count == {1'b0, frame_len})
                r.status = ST_ACCEPT;
            else
                r.status = ST_MISMATCH;  // covers a chunk cut inside the header
            clear_deframer();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender: presents chunk words at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : sender
        chunk_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !word_taken) begin
            // word still waiting for s_tready, hold it
        end else if (send_wait != 0) begin
            s_tvalid  <= 1'b0;
            send_wait <= send_wait - 1;
        end else if (chunk_bytes_q.size() != 0 &&
                     !(chunk_bytes_q[0].drain && deframed_q.size() != 0)) begin
            w = chunk_bytes_q.pop_front();
            s_tvalid  <= 1'b1;
            s_tdata   <= w.data;
            s_tlast   <= w.last;
            quiet     <= w.quiet;
            send_wait <= w.quiet ? 0 : $urandom_range(0, 6);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver: draws a stall for every result word it takes
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : receiver
        int stall;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else begin
            stall = recv_wait;
            if (result_taken)
                stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_tready  <= 1'b0;
                recv_wait <= stall - 1;
            end else begin
                m_tready  <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    task automatic log_miss(string what, deframed_word_t exp);
        bad_words = bad_words + 1;
        if (bad_words <= 10)
            $display("%0t: %s: exp byte %02h valid %0b done %0b status %0d, got %04h %0b %0b",
                     $realtime, what, exp.out_byte, exp.byte_valid, exp.frame_done,
                     exp.status, m_tdata, m_tuser, m_tlast);
    endtask

    // ------------------------------------------------------------------
    // monitor: checks result words and predicts accepted chunk words
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        deframed_word_t exp;
        if (!aresetn) begin
            clear_deframer();
            word_taken   <= 1'b0;
            result_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (deframed_q.size() == 0) begin
                    exp = '0;
                    log_miss("unexpected result word", exp);
                end else begin
                    exp = deframed_q.pop_front();
                    if (m_tdata[7:0] !== exp.out_byte || m_tdata[10:8] !== exp.status ||
                        m_tdata[15:11] !== 5'd0 || m_tuser !== exp.byte_valid ||
                        m_tlast !== exp.frame_done)
                        log_miss("result mismatch", exp);
                end
            end
            result_taken <= m_tvalid && m_tready;
            word_taken   <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                deframed_q.push_back(deframe_byte(s_tdata, s_tlast));
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(logic [7:0] d, logic l);
        chunk_word_t w;
        w.data  = d;
        w.last  = l;
        w.drain = drain_pending;
        w.quiet = quiet_mode;
        drain_pending = 1'b0;
        chunk_bytes_q.push_back(w);
    endtask

    // header byte, length byte with a random mask bit, optional 16-bit length,
    // a random key and n_data random payload bytes; cut > 0 keeps only that many
    task automatic queue_frame(logic [7:0] hdr0, logic [6:0] len7, logic [15:0] ext_len,
                               int n_data, int cut);
        logic [7:0]  chunk[$];
        logic [31:0] key;
        logic        mbit;
        int          i;
        key  = $urandom();
        mbit = 1'($urandom_range(0, 1));
        chunk.push_back(hdr0);
        chunk.push_back({mbit, len7});
        if (len7 == LEN_EXT16) begin
            chunk.push_back(ext_len[15:8]);
            chunk.push_back(ext_len[7:0]);
        end
        for (i = 0; i < 4; i++)
            chunk.push_back(key[31-8*i -: 8]);
        for (i = 0; i < n_data; i++)
            chunk.push_back(8'($urandom()));
        if (cut > 0)
            while (chunk.size() > cut)
                void'(chunk.pop_back());
        for (i = 0; i < chunk.size(); i++)
            queue_word(chunk[i], i == chunk.size() - 1);
    endtask

    task automatic queue_random_part(int n_words);
        int          start;
        int          frames;
        int          pick;
        int          n_data;
        int          hdr_len;
        int          i;
        logic [2:0]  rsv;
        logic [6:0]  len7;
        logic [15:0] ext_len;
        logic [7:0]  hdr0;
        start  = chunk_bytes_q.size();
        frames = 0;
        while (chunk_bytes_q.size() - start < n_words) begin
            // calm stretches with no idling now and then
            if (frames % 16 == 0)
                quiet_mode = ($urandom_range(0, 4) == 0);
            // let the pipe run dry every so often
            if (frames % 40 == 39)
                drain_pending = 1'b1;
            frames++;
            pick = $urandom_range(0, 99);
            rsv  = 3'($urandom());
            if (pick < 75) begin
                // binary frame with random content; some get excess or short payload or are cut
                hdr0 = {1'b1, rsv, OPC_BINARY};
                if ($urandom_range(0, 4) == 0) begin
                    len7    = LEN_EXT16;
                    ext_len = ($urandom_range(0, 5) == 0) ? 16'($urandom())
                                                          : 16'($urandom_range(0, 12));
                    n_data  = (ext_len > 12) ? $urandom_range(0, 12) : int'(ext_len);
                    hdr_len = 8;
                end else begin
                    len7    = 7'($urandom_range(0, 12));
                    ext_len = '0;
                    n_data  = int'(len7);
                    hdr_len = 6;
                end
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    n_data = n_data + $urandom_range(1, 3);           // excess payload
                else if (pick == 1 && n_data > 0)
                    n_data = n_data - $urandom_range(1, n_data < 3 ? n_data : 3);
                queue_frame(hdr0, len7, ext_len, n_data,
                            (pick == 2) ? $urandom_range(1, hdr_len) : 0);
            end else if (pick < 90) begin
                // rejected frame: random header byte or 64-bit length, random tail
                if ($urandom_range(0, 3) == 0)
                    queue_frame({1'b1, rsv, OPC_BINARY}, LEN_EXT64, '0,
                                $urandom_range(0, 4), 0);
                else
                    queue_frame(8'($urandom()), 7'($urandom()), 16'($urandom()),
                                $urandom_range(0, 4), $urandom_range(1, 8));
            end else begin
                // plain noise chunk
                n_data = $urandom_range(1, 8);
                for (i = 0; i < n_data; i++)
                    queue_word(8'($urandom()), i == n_data - 1);
            end
        end
        quiet_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // directed: each verdict, field extremes, ignored mask bit
        queue_word(8'h02, 1'b1);                          // fin clear
        queue_word(8'h88, 1'b0);                          // close opcode
        queue_word(8'hFF, 1'b1);
        queue_word(8'h81, 1'b1);                          // text opcode, not binary
        queue_word(8'h82, 1'b0);                          // 64-bit length
        queue_word(8'hFF, 1'b1);
        queue_frame(8'h82, 7'd0, '0, 0, 0);               // zero length right after key
        queue_frame(8'h82, LEN_EXT16, 16'hFFFF, 2, 0);    // extended length, too short
        queue_frame(8'h82, 7'd1, '0, 1, 0);               // exact payload
        queue_word(8'h82, 1'b1);                          // chunk cut in the header

        drain_pending = 1'b1;
        queue_random_part(1000);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (chunk_bytes_q.size() != 0 || s_tvalid)
            @(negedge aclk);
        while (deframed_q.size() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);

        if (bad_words == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ websocket_frame_deframer.f @@
+incdir+design
design/wsdf_pkg.sv
design/websocket_frame_deframer.sv
design/wsdf_checker.sv
tb/tb_websocket_frame_deframer.sv
